// ===== rtl/core/bilateral_filter_window_defines.svh =====
// Assertion macros shared by the bilateral filter RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef BILATERAL_FILTER_WINDOW_DEFINES_SVH
`define BILATERAL_FILTER_WINDOW_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BFW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BFW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bfw_pkg.sv =====
// Shared constants, types, state encodings and helpers for the bilateral filter.
// No dependencies.
`default_nettype none

package bfw_pkg;

    localparam int KERNEL_RADIUS = 2;
    localparam int MAX_WIDTH     = 1024;
    localparam int WEIGHT_BITS   = 16;

    localparam int KSIZE      = 2 * KERNEL_RADIUS + 1;
    localparam int NLINES     = 2 * KERNEL_RADIUS;
    localparam int SP_DEPTH   = 2 * KERNEL_RADIUS * KERNEL_RADIUS + 1;
    localparam int LINE_DEPTH = NLINES * MAX_WIDTH;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int LINE_SEL_W = (NLINES > 1) ? $clog2(NLINES) : 1;
    localparam int RD_CNT_W   = $clog2(NLINES + 1);
    localparam int KIDX_W     = $clog2(KSIZE);
    localparam int SP_AW      = $clog2(SP_DEPTH);
    localparam int TAPS       = KSIZE * KSIZE;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 16;
    localparam int CMD_W      = 2;
    localparam int TIDX_W     = 8;
    localparam int WVAL_W     = 16;
    localparam int RANGE_DEPTH = 256;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int WEFF_W     = XW + 1;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    localparam int PROD_W   = 2 * WEIGHT_BITS;
    localparam int WPIX_W   = PROD_W + PIX_W;
    localparam int ACC_BITS = $clog2(TAPS);
    localparam int NUM_W    = WPIX_W + ACC_BITS;
    localparam int DEN_W    = PROD_W + ACC_BITS;
    localparam int QBITS    = PIX_W + 1;
    localparam int QCNT_W   = $clog2(QBITS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PIXEL    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RANGE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPATIAL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]       pix_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PIX_W-1:0]  pixel;
        logic [TIDX_W-1:0] table_index;
        logic [WVAL_W-1:0] weight_value;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [PIX_W-1:0] filtered;
    } out_item_t;

    // Control from the sequencer into the filter core
    typedef struct packed {
        logic              start;
        logic              rw_en;
        logic [TIDX_W-1:0] rw_addr;
        weight_t           rw_data;
    } core_ctrl_t;

    // Status back from the filter core
    typedef struct packed {
        logic done;
        pix_t filtered;
    } core_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FILTER,
        ST_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        FC_IDLE,
        FC_ACC,
        FC_DIV,
        FC_ROUND
    } core_state_t;

    // Squared distance of window tap (tr, tc) from the center
    function automatic logic [SP_AW-1:0] tap_dist2(input logic [KIDX_W-1:0] tr,
                                                   input logic [KIDX_W-1:0] tc);
        logic [KIDX_W-1:0] dy;
        logic [KIDX_W-1:0] dx;
        logic [SP_AW:0]    sum;
        dy = (tr >= KIDX_W'(KERNEL_RADIUS)) ? tr - KIDX_W'(KERNEL_RADIUS)
                                            : KIDX_W'(KERNEL_RADIUS) - tr;
        dx = (tc >= KIDX_W'(KERNEL_RADIUS)) ? tc - KIDX_W'(KERNEL_RADIUS)
                                            : KIDX_W'(KERNEL_RADIUS) - tc;
        sum = (SP_AW+1)'(dy) * (SP_AW+1)'(dy) + (SP_AW+1)'(dx) * (SP_AW+1)'(dx);
        return sum[SP_AW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bilateral_filter_window.sv =====
// Bilateral filter over a (2R+1)x(2R+1) window on a raster pixel stream.
// Depends on bfw_pkg, bfw_line_mem, bfw_filter_core and the assertion macros.
//
// Usage:
//   s_ channel carries commands: pixel, range-weight load, spatial-weight load.
//   m_ channel carries one result per emitted center (row, col, filtered value).
//   cfg_we/cfg_index/cfg_wdata set image width (0) and height (1), while idle.
// Sequence:
//   A table load is written as it is accepted. A pixel fetches its column from
//   the line store (one read per line, one registered port) and updates the
//   window. Border centers are then emitted with value 0. An interior center
//   runs 25 taps through the multiply pipeline, then a shift-subtract divide,
//   a rounding step and a handoff; no new item is accepted until the result
//   is loaded into the output register.
//   The first R rows and columns produce no output; the last R are never shown.
// Reset:
//   Counters, window and weight tables clear; line store contents are undefined
//   but never reach a result. Geometry returns to 1024x1024.
// Backpressure:
//   The result sits in an output register; the next item is accepted while it
//   waits, and the sequencer holds only when a second result is ready.
`default_nettype none
`include "bilateral_filter_window_defines.svh"

module bilateral_filter_window
    import bfw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    seq_state_t state_reg, state_next;

    logic [CFG_WIDTH_W-1:0]  cfg_width_reg;
    logic [CFG_HEIGHT_W-1:0] cfg_height_reg;
    logic [XW-1:0]           col_count_reg;
    logic [ROW_W-1:0]        row_count_reg;
    logic [LINE_SEL_W-1:0]   line_reg;
    logic [XW-1:0]           x_reg;
    logic [ROW_W-1:0]        y_reg;
    logic [LINE_SEL_W-1:0]   yline_reg;
    pix_t                    pix_reg;
    logic [RD_CNT_W-1:0]     rd_cnt_reg;
    pix_t                    column_reg [NLINES];
    pix_t                    window_reg [KSIZE][KSIZE];
    weight_t                 spatial_reg [SP_DEPTH];
    pix_t                    filt_reg;
    logic                    start_reg;
    logic                    m_valid_reg;
    out_item_t               out_reg;

    logic [WEFF_W-1:0]     w_eff;
    logic [ROW_W-1:0]      h_eff;
    logic                  accept, acc_pixel, rd_done, out_load;
    logic [XW-1:0]         x_acc;
    logic [ROW_W-1:0]      y_acc;
    logic [LINE_SEL_W-1:0] yline_acc;
    logic [LINE_SEL_W:0]   sel_sum;
    logic [LINE_SEL_W-1:0] rd_sel;
    logic [LINE_AW-1:0]    raddr, waddr;
    pix_t                  rdata;
    pix_t                  col_full [KSIZE];
    logic                  emit, interior;
    logic [WEFF_W-1:0]     x_inc;
    logic [ROW_W:0]        y_inc;
    logic [LINE_SEL_W:0]   line_inc;
    core_ctrl_t            core_ctrl;
    core_stat_t            core_stat;

    // Effective geometry
    always_comb begin
        if (cfg_width_reg == '0) begin
            w_eff = WEFF_W'(1);
        end else if (int'(cfg_width_reg) > MAX_WIDTH) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(cfg_width_reg);
        end
        h_eff = (cfg_height_reg == '0) ? ROW_W'(1) : cfg_height_reg;
    end

    // Position of the incoming pixel, wrapped against current geometry
    assign accept    = s_valid && s_ready;
    assign acc_pixel = accept && (s_data.command == CMD_PIXEL);
    assign x_acc     = ({1'b0, col_count_reg} >= w_eff) ? '0 : col_count_reg;
    assign y_acc     = (row_count_reg >= h_eff) ? '0 : row_count_reg;
    assign yline_acc = (row_count_reg >= h_eff) ? '0 : line_reg;

    // Line store addressing
    assign sel_sum = (LINE_SEL_W+1)'(yline_reg) + (LINE_SEL_W+1)'(rd_cnt_reg);
    assign rd_sel  = (sel_sum >= (LINE_SEL_W+1)'(NLINES)) ?
                     LINE_SEL_W'(sel_sum - (LINE_SEL_W+1)'(NLINES)) : sel_sum[LINE_SEL_W-1:0];
    assign raddr   = LINE_AW'(rd_sel) * LINE_AW'(MAX_WIDTH) + LINE_AW'(x_reg);
    assign waddr   = LINE_AW'(yline_reg) * LINE_AW'(MAX_WIDTH) + LINE_AW'(x_reg);

    bfw_line_mem u_line (
        .aclk  (aclk),
        .we    (rd_done),
        .waddr (waddr),
        .wdata (pix_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // New window column: stored lines, the last read in flight, then the pixel
    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            if (r == NLINES) begin
                col_full[r] = pix_reg;
            end else if (r == NLINES - 1) begin
                col_full[r] = rdata;
            end else begin
                col_full[r] = column_reg[r];
            end
        end
    end

    assign emit     = (y_reg >= ROW_W'(KERNEL_RADIUS)) && (x_reg >= XW'(KERNEL_RADIUS));
    assign interior = (y_reg >= ROW_W'(2 * KERNEL_RADIUS)) &&
                      (x_reg >= XW'(2 * KERNEL_RADIUS));
    assign x_inc    = WEFF_W'(x_reg) + 1'b1;
    assign y_inc    = (ROW_W+1)'(y_reg) + 1'b1;
    assign line_inc = (LINE_SEL_W+1)'(yline_reg) + 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc_pixel) state_next = ST_READ;
            end
            ST_READ: begin
                if (rd_done) begin
                    if (interior) state_next = ST_FILTER;
                    else if (emit) state_next = ST_OUT;
                    else state_next = ST_IDLE;
                end
            end
            ST_FILTER: begin
                if (core_stat.done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        rd_done  = (state_reg == ST_READ) && (rd_cnt_reg == RD_CNT_W'(NLINES));
        out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    // Control state: state, geometry, counters, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cfg_width_reg  <= CFG_WIDTH_W'(1024);
            cfg_height_reg <= CFG_HEIGHT_W'(1024);
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            line_reg       <= '0;
            start_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= rd_done && interior;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_WIDTH:  cfg_width_reg  <= cfg_wdata[CFG_WIDTH_W-1:0];
                    REG_HEIGHT: cfg_height_reg <= cfg_wdata[CFG_HEIGHT_W-1:0];
                    default:    cfg_width_reg  <= cfg_width_reg;
                endcase
            end
            if (rd_done) begin
                if (x_inc >= w_eff) begin
                    col_count_reg <= '0;
                    if (y_inc >= (ROW_W+1)'(h_eff)) begin
                        row_count_reg <= '0;
                        line_reg      <= '0;
                    end else begin
                        row_count_reg <= y_inc[ROW_W-1:0];
                        line_reg      <= (line_inc >= (LINE_SEL_W+1)'(NLINES)) ?
                                         '0 : line_inc[LINE_SEL_W-1:0];
                    end
                end else begin
                    col_count_reg <= x_inc[XW-1:0];
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Window and spatial weights reset to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < KSIZE; r++) begin
                for (int c = 0; c < KSIZE; c++) begin
                    window_reg[r][c] <= '0;
                end
            end
            for (int i = 0; i < SP_DEPTH; i++) begin
                spatial_reg[i] <= '0;
            end
        end else begin
            if (accept && s_data.command == CMD_SPATIAL &&
                int'(s_data.table_index) < SP_DEPTH) begin
                spatial_reg[SP_AW'(s_data.table_index)] <= s_data.weight_value;
            end
            if (rd_done) begin
                for (int r = 0; r < KSIZE; r++) begin
                    for (int c = 0; c < KSIZE - 1; c++) begin
                        window_reg[r][c] <= window_reg[r][c + 1];
                    end
                    window_reg[r][KSIZE - 1] <= col_full[r];
                end
            end
        end
    end

    // Per-transaction payload registers
    always_ff @(posedge aclk) begin
        if (acc_pixel) begin
            x_reg      <= x_acc;
            y_reg      <= y_acc;
            yline_reg  <= yline_acc;
            pix_reg    <= s_data.pixel;
            rd_cnt_reg <= '0;
        end else if (state_reg == ST_READ) begin
            if (rd_cnt_reg != '0) begin
                column_reg[LINE_SEL_W'(rd_cnt_reg - 1'b1)] <= rdata;
            end
            rd_cnt_reg <= rd_cnt_reg + 1'b1;
        end
        if (rd_done) begin
            filt_reg <= '0;
        end else if (core_stat.done) begin
            filt_reg <= core_stat.filtered;
        end
        if (out_load) begin
            out_reg.out_row  <= y_reg - ROW_W'(KERNEL_RADIUS);
            out_reg.out_col  <= COL_W'(x_reg - XW'(KERNEL_RADIUS));
            out_reg.filtered <= filt_reg;
        end
    end

    // Filter core control
    assign core_ctrl.start   = start_reg;
    assign core_ctrl.rw_en   = accept && (s_data.command == CMD_RANGE);
    assign core_ctrl.rw_addr = s_data.table_index;
    assign core_ctrl.rw_data = s_data.weight_value;

    bfw_filter_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (core_ctrl),
        .win     (window_reg),
        .spatial (spatial_reg),
        .stat    (core_stat)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A pixel transaction keeps the input closed while its column is fetched
    `BFW_ASSERT_NXT(a_pixel_busy, acc_pixel, !s_ready, "input open during pixel fetch")
    // Loading the output register always presents a result
    `BFW_ASSERT_NXT(a_out_load, out_load, m_valid, "result load did not raise m_valid")
    // The core only finishes while the sequencer waits on it
    `BFW_ASSERT_IMP(a_core_done, core_stat.done, state_reg == ST_FILTER, "stray core done")

endmodule

`default_nettype wire

// ===== rtl/core/bfw_line_mem.sv =====
// Line store: NLINES rows of MAX_WIDTH pixels, one write and one read port.
// Depends on bfw_pkg.
`default_nettype none

module bfw_line_mem
    import bfw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [LINE_AW-1:0] waddr,
    input  wire pix_t               wdata,
    input  wire logic [LINE_AW-1:0] raddr,
    output pix_t                    rdata
);

    pix_t mem_reg [LINE_DEPTH];
    pix_t rdata_reg;

    // Synchronous write, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bfw_range_mem.sv =====
// Range weight table with per-entry valid bits; unwritten entries read as zero.
// Depends on bfw_pkg.
`default_nettype none

module bfw_range_mem
    import bfw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              we,
    input  wire logic [TIDX_W-1:0] waddr,
    input  wire weight_t           wdata,
    input  wire logic [TIDX_W-1:0] raddr,
    output weight_t                rdata
);

    weight_t                mem_reg [RANGE_DEPTH];
    logic [RANGE_DEPTH-1:0] valid_reg;
    weight_t                data_reg;
    logic                   hit_reg;

    // Table storage and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        data_reg <= mem_reg[raddr];
    end

    // Valid bits clear at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            hit_reg <= valid_reg[raddr];
        end
    end

    assign rdata = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/core/bfw_filter_core.sv =====
// Filter core: walks the window one tap a cycle through a multiply pipeline,
// accumulates numerator and denominator, then divides one quotient bit a cycle.
// Depends on bfw_pkg and bfw_range_mem.
`default_nettype none

module bfw_filter_core
    import bfw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire core_ctrl_t ctrl,
    input  wire pix_t       win [KSIZE][KSIZE],
    input  wire weight_t    spatial [SP_DEPTH],
    output core_stat_t      stat
);

    core_state_t state_reg, state_next;

    logic [KIDX_W-1:0] tr_reg, tc_reg;
    logic              issue_reg;
    logic              v1_reg, l1_reg, v2_reg, l2_reg, v3_reg, l3_reg;
    pix_t              nb1_reg, nb2_reg;
    weight_t           sp1_reg;
    logic [PROD_W-1:0] w2_reg, w3_reg;
    logic [WPIX_W-1:0] wp3_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QBITS-1:0]  q_reg;
    logic [QCNT_W-1:0] div_cnt_reg;
    logic              done_reg;
    pix_t              filt_reg;

    pix_t              nb, center, diff;
    logic              last_tap;
    weight_t           rg_rdata;
    logic [NUM_W-1:0]  den_shift;
    logic              div_ge;
    logic [DEN_W:0]    rem_x2;
    logic              round_up;
    logic [QBITS-1:0]  q_round;

    // Tap selection for the current issue slot
    assign center   = win[KERNEL_RADIUS][KERNEL_RADIUS];
    assign nb       = win[tr_reg][tc_reg];
    assign diff     = (nb > center) ? nb - center : center - nb;
    assign last_tap = (tr_reg == KIDX_W'(KSIZE - 1)) && (tc_reg == KIDX_W'(KSIZE - 1));

    bfw_range_mem u_range (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ctrl.rw_en),
        .waddr   (ctrl.rw_addr),
        .wdata   (ctrl.rw_data),
        .raddr   (diff),
        .rdata   (rg_rdata)
    );

    // Divider step and rounding terms
    assign den_shift = NUM_W'(den_reg) << div_cnt_reg;
    assign div_ge    = num_reg >= den_shift;
    assign rem_x2    = {num_reg[DEN_W-1:0], 1'b0};
    assign round_up  = (rem_x2 > {1'b0, den_reg}) ||
                       ((rem_x2 == {1'b0, den_reg}) && q_reg[0]);
    assign q_round   = q_reg + QBITS'(round_up);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FC_IDLE:  if (ctrl.start) state_next = FC_ACC;
            FC_ACC:   if (v3_reg && l3_reg) state_next = FC_DIV;
            FC_DIV:   if (div_cnt_reg == '0) state_next = FC_ROUND;
            FC_ROUND: state_next = FC_IDLE;
            default:  state_next = FC_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FC_IDLE;
            issue_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == FC_ROUND);
            v1_reg    <= issue_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (state_reg == FC_IDLE && ctrl.start) begin
                issue_reg <= 1'b1;
            end else if (issue_reg && last_tap) begin
                issue_reg <= 1'b0;
            end
        end
    end

    // Tap walk, multiply pipeline, accumulate, divide
    always_ff @(posedge aclk) begin
        l1_reg  <= last_tap;
        l2_reg  <= l1_reg;
        l3_reg  <= l2_reg;
        nb1_reg <= nb;
        sp1_reg <= spatial[tap_dist2(tr_reg, tc_reg)];
        nb2_reg <= nb1_reg;
        w2_reg  <= sp1_reg * rg_rdata;
        w3_reg  <= w2_reg;
        wp3_reg <= w2_reg * nb2_reg;

        if (state_reg == FC_IDLE && ctrl.start) begin
            tr_reg  <= '0;
            tc_reg  <= '0;
            num_reg <= '0;
            den_reg <= '0;
            q_reg   <= '0;
        end else begin
            if (issue_reg) begin
                if (tc_reg == KIDX_W'(KSIZE - 1)) begin
                    tc_reg <= '0;
                    tr_reg <= tr_reg + 1'b1;
                end else begin
                    tc_reg <= tc_reg + 1'b1;
                end
            end
            if (state_reg == FC_ACC && v3_reg) begin
                num_reg     <= num_reg + NUM_W'(wp3_reg);
                den_reg     <= den_reg + DEN_W'(w3_reg);
                div_cnt_reg <= QCNT_W'(QBITS - 1);
            end
            if (state_reg == FC_DIV) begin
                if (div_ge) begin
                    num_reg            <= num_reg - den_shift;
                    q_reg[div_cnt_reg] <= 1'b1;
                end
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
        end

        if (state_reg == FC_ROUND) begin
            if (den_reg == '0) begin
                filt_reg <= '0;
            end else if (q_round > QBITS'(255)) begin
                filt_reg <= 8'd255;
            end else begin
                filt_reg <= q_round[PIX_W-1:0];
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.filtered = filt_reg;

endmodule

`default_nettype wire

// ===== verif/bilateral_filter_window_checker.sv =====
// Result checker for the bilateral filter window: mirrors the filter state,
// predicts each result from accepted transactions and compares. Needs bfw_pkg.
module bilateral_filter_window_checker
    import bfw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [10:0] img_w;
    logic [15:0] img_h;
    logic [7:0]  lines [NLINES*MAX_WIDTH];
    logic [7:0]  win [KSIZE][KSIZE];
    logic [15:0] rng_tab [256];
    logic [15:0] sp_tab [SP_DEPTH];
    int unsigned col_pos, row_pos;
    out_item_t   expected_q [$];

    // Weighted average of the current window, rounded half to even
    function automatic logic [7:0] smooth_center();
        logic [63:0] num, den, q, rem, w;
        logic [7:0]  ctr, nb, diff;
        int d2;
        num = 0;
        den = 0;
        ctr = win[KERNEL_RADIUS][KERNEL_RADIUS];
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
                nb = win[r][c];
                d2 = (r - KERNEL_RADIUS) * (r - KERNEL_RADIUS)
                   + (c - KERNEL_RADIUS) * (c - KERNEL_RADIUS);
                diff = (nb > ctr) ? nb - ctr : ctr - nb;
                w = 64'(sp_tab[d2]) * 64'(rng_tab[diff]);
                num += w * nb;
                den += w;
            end
        end
        if (den == 0) return 8'd0;
        q = num / den;
        rem = num - q * den;
        if (2 * rem > den || (2 * rem == den && q[0])) q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Advance the mirrored state by one accepted transaction
    task automatic apply_item(input in_item_t it);
        int unsigned wd, ht, x, y;
        logic [7:0]  col [KSIZE];
        out_item_t   res;
        if (it.command == CMD_RANGE) begin
            rng_tab[it.table_index] = it.weight_value;
        end else if (it.command == CMD_SPATIAL) begin
            if (it.table_index < SP_DEPTH) sp_tab[it.table_index] = it.weight_value;
        end else if (it.command == CMD_PIXEL) begin
            wd = (img_w == 0) ? 1 : (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
            ht = (img_h == 0) ? 1 : img_h;
            if (col_pos >= wd) col_pos = 0;
            if (row_pos >= ht) row_pos = 0;
            x = col_pos;
            y = row_pos;
            for (int r = 0; r < NLINES; r++)
                col[r] = lines[((y + r) % NLINES) * MAX_WIDTH + x];
            col[NLINES] = it.pixel;
            lines[(y % NLINES) * MAX_WIDTH + x] = it.pixel;
            for (int r = 0; r < KSIZE; r++) begin
                for (int c = 0; c < KSIZE - 1; c++) win[r][c] = win[r][c+1];
                win[r][KSIZE-1] = col[r];
            end
            if (y >= KERNEL_RADIUS && x >= KERNEL_RADIUS) begin
                res.out_row = 16'(y - KERNEL_RADIUS);
                res.out_col = 10'(x - KERNEL_RADIUS);
                res.filtered = (y >= 2 * KERNEL_RADIUS && x >= 2 * KERNEL_RADIUS)
                             ? smooth_center() : 8'd0;
                expected_q.push_back(res);
            end
            col_pos = x + 1;
            if (col_pos >= wd) begin
                col_pos = 0;
                row_pos = y + 1;
                if (row_pos >= ht) row_pos = 0;
            end
        end
    endtask

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        out_item_t exp_item;
        if (!aresetn) begin
            img_w = 11'd1024;
            img_h = 16'd1024;
            col_pos = 0;
            row_pos = 0;
            fail_count = 0;
            expected_q.delete();
            for (int r = 0; r < KSIZE; r++)
                for (int c = 0; c < KSIZE; c++) win[r][c] = '0;
            foreach (rng_tab[i]) rng_tab[i] = '0;
            foreach (sp_tab[i]) sp_tab[i] = '0;
            foreach (lines[i]) lines[i] = '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_WIDTH) img_w = cfg_wdata[10:0];
                else if (cfg_index == REG_HEIGHT) img_h = cfg_wdata;
            end
            if (s_valid && s_ready) apply_item(s_data);
            // Compare each result transaction with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result row %0d col %0d val %0d",
                                 m_data.out_row, m_data.out_col, m_data.filtered);
                end else begin
                    exp_item = expected_q.pop_front();
                    if (exp_item.out_row !== m_data.out_row
                        || exp_item.out_col !== m_data.out_col
                        || exp_item.filtered !== m_data.filtered) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp r%0d c%0d v%0d, got r%0d c%0d v%0d",
                                     exp_item.out_row, exp_item.out_col,
                                     exp_item.filtered, m_data.out_row,
                                     m_data.out_col, m_data.filtered);
                    end
                end
            end
        end
    end
endmodule

// ===== verif/bilateral_filter_window_test.sv =====
// Stimulus top for the bilateral filter window: loads weight tables, streams
// small frames under varying flow control. Needs bfw_pkg and the checker.
module bilateral_filter_window_test
    import bfw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    int                    fail_count, pending;
    int                    send_idle = 0, recv_stall = 0;
    int                    hold_off = 0;
    int                    quiet_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    bilateral_filter_window u_top (.*);

    bilateral_filter_window_checker u_chk (.*);

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Watchdog on cycles with no transaction anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Valid stays up after a transaction until the next one or an idle cycle
    task automatic send(input logic [1:0] cmd, input logic [7:0] pix,
                        input logic [7:0] idx, input logic [15:0] wv);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{command: cmd, pixel: pix, table_index: idx, weight_value: wv};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Dense for small differences, sparse above
    task automatic load_gaussian_tables(input int spread);
        for (int d = 0; d < 256; d += (d < 8) ? 1 : 31)
            send(CMD_RANGE, 8'($urandom), 8'(d),
                 (d * spread > 4000) ? 16'd0 : 16'(65535 - d * spread * 16));
        for (int d = 0; d < SP_DEPTH; d++)
            send(CMD_SPATIAL, 8'($urandom), 8'(d), 16'(65535 >> d));
    endtask

    // Frame of given size: smooth ramp plus noise
    task automatic stream_frame(input int wd, input int ht, input int noise);
        for (int y = 0; y < ht; y++)
            for (int x = 0; x < wd; x++)
                send(CMD_PIXEL, 8'((x * 13 + y * 7 + $urandom_range(noise)) & 255),
                     8'($urandom), 16'($urandom));
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: small geometry, table edges, ignored commands
        write_reg(REG_WIDTH, 16'd5);
        write_reg(REG_HEIGHT, 16'd5);
        send(CMD_SPATIAL, 8'hFF, 8'd255, 16'hFFFF);
        send(CMD_SPATIAL, 8'h00, 8'(SP_DEPTH), 16'h1234);
        send(CMD_RESERVED, 8'hAA, 8'h55, 16'h5555);
        send(CMD_PIXEL, 8'd0, 8'd0, 16'd0);
        send(CMD_PIXEL, 8'd255, 8'hFF, 16'hFFFF);
        // zero weights: all interior results are zero
        for (int i = 0; i < 23; i++)
            send(CMD_PIXEL, 8'($urandom), 8'($urandom), 16'($urandom));
        drain();
        send(CMD_RANGE, 8'd0, 8'd0, 16'hFFFF);
        send(CMD_RANGE, 8'd0, 8'd255, 16'hFFFF);
        send(CMD_SPATIAL, 8'd0, 8'd0, 16'hFFFF);
        send(CMD_SPATIAL, 8'd0, 8'(SP_DEPTH - 1), 16'h0001);
        for (int i = 0; i < 25; i++)
            send(CMD_PIXEL, (i % 2) ? 8'd255 : 8'd0, 8'd0, 16'd0);
        drain();

        // Random: several geometries and flow-control phases
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 55; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 55; end
                default: begin send_idle = 14; recv_stall = 14; end
            endcase
            write_reg(REG_WIDTH, (ph == 7) ? 16'd2047 : 16'($urandom_range(5, 9)));
            write_reg(REG_HEIGHT, (ph == 6) ? 16'd65535 : 16'($urandom_range(5, 8)));
            load_gaussian_tables($urandom_range(1, 60));
            if (ph == 2) hold_off = 400;
            stream_frame(7, 6, (ph % 2) ? 255 : 10);
            drain();
        end
        // Width 0 acts as 1, and so does height 0
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'd0);
        stream_frame(1, 6, 255);
        drain();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
